/* design/spq_pkg.sv */
// ----------------------------------------------------------------------------
// spq_pkg
// Shared types and constants for the sorted priority queue.
// ----------------------------------------------------------------------------
`default_nettype none

package spq_pkg;

  // Queue capacity and derived widths
  localparam int DEPTH  = 8;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int WORD_W = 32;

  // Request kinds
  localparam logic REQ_INSERT = 1'b0;
  localparam logic REQ_REMOVE = 1'b1;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  // One stored entry
  typedef struct packed {
    logic signed [WORD_W-1:0] prio;
    logic signed [WORD_W-1:0] value;
  } entry_t;

  // One result item
  typedef struct packed {
    status_t                  status;
    logic signed [WORD_W-1:0] value;
    logic signed [WORD_W-1:0] prio;
  } result_t;

endpackage

`default_nettype wire

/* design/spq_core.sv */
// ----------------------------------------------------------------------------
// spq_core
// Sorted entry store and its sequencer. One memory read port and one write
// port are reused each step to shift entries, with one comparator on insert.
// ----------------------------------------------------------------------------
`default_nettype none

module spq_core import spq_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst,
  // request side
  input  wire logic    req_valid,
  output logic         req_ready,
  input  wire logic    req_type,
  input  wire entry_t  req_entry,
  // result side
  output logic         res_valid,
  input  wire logic    res_ready,
  output result_t      res
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_INS_CMP,
    S_REM_HEAD,
    S_REM_SHIFT,
    S_FIN
  } state_t;

  state_t            state;
  logic [CNT_W-1:0]  count;
  logic [CNT_W-1:0]  idx;
  entry_t            new_entry;

  // Entry memory, registered read
  entry_t            mem [DEPTH];
  entry_t            rd_data;
  logic              we;
  logic [ADDR_W-1:0] waddr;
  logic [ADDR_W-1:0] raddr;
  entry_t            wdata;

  logic [CNT_W-1:0]  idx_m1;
  logic [CNT_W-1:0]  idx_m2;
  logic [CNT_W-1:0]  idx_p1;
  logic [CNT_W-1:0]  cnt_m1;
  logic              is_full;
  logic              is_empty;
  logic              new_greater;

  assign idx_m1      = idx - CNT_W'(1);
  assign idx_m2      = idx - CNT_W'(2);
  assign idx_p1      = idx + CNT_W'(1);
  assign cnt_m1      = count - CNT_W'(1);
  assign is_full     = (count == CNT_W'(DEPTH));
  assign is_empty    = (count == '0);
  // Shared comparator: new entry moves ahead only of strictly lower priority
  assign new_greater = (new_entry.prio > rd_data.prio);

  assign req_ready = (state == S_IDLE);
  assign res_valid = (state == S_FIN);

  // Memory port control
  always_comb begin
    we    = 1'b0;
    waddr = idx[ADDR_W-1:0];
    wdata = new_entry;
    raddr = '0;
    case (state)
      S_IDLE: begin
        if (req_valid && req_type == REQ_INSERT) begin
          if (is_empty) begin
            we    = 1'b1;
            waddr = '0;
            wdata = req_entry;
          end else begin
            raddr = cnt_m1[ADDR_W-1:0];
          end
        end
      end
      S_INS_CMP: begin
        we = 1'b1;
        if (idx == '0) begin
          waddr = '0;
        end else if (new_greater) begin
          wdata = rd_data;
          raddr = idx_m2[ADDR_W-1:0];
        end
      end
      S_REM_HEAD: begin
        raddr = ADDR_W'(1);
      end
      S_REM_SHIFT: begin
        we    = 1'b1;
        waddr = idx_m1[ADDR_W-1:0];
        wdata = rd_data;
        raddr = idx_p1[ADDR_W-1:0];
      end
      default: begin
      end
    endcase
  end

  // Memory array
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_data <= mem[raddr];
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      idx   <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (req_valid) begin
            new_entry  <= req_entry;
            res.value  <= '0;
            res.prio   <= '0;
            res.status <= ST_OK;
            if (req_type == REQ_INSERT) begin
              if (is_full) begin
                res.status <= ST_FULL;
                state      <= S_FIN;
              end else if (is_empty) begin
                count <= CNT_W'(1);
                state <= S_FIN;
              end else begin
                idx   <= count;
                state <= S_INS_CMP;
              end
            end else begin
              if (is_empty) begin
                res.status <= ST_EMPTY;
                state      <= S_FIN;
              end else begin
                state <= S_REM_HEAD;
              end
            end
          end
        end
        // Walk from the rear, shifting lower-priority entries back by one
        S_INS_CMP: begin
          if (idx == '0 || !new_greater) begin
            count <= count + CNT_W'(1);
            state <= S_FIN;
          end else begin
            idx <= idx_m1;
          end
        end
        // Capture head, then shift the rest forward
        S_REM_HEAD: begin
          res.value <= rd_data.value;
          res.prio  <= rd_data.prio;
          if (count == CNT_W'(1)) begin
            count <= '0;
            state <= S_FIN;
          end else begin
            idx   <= CNT_W'(1);
            state <= S_REM_SHIFT;
          end
        end
        S_REM_SHIFT: begin
          if (idx_p1 == count) begin
            count <= cnt_m1;
            state <= S_FIN;
          end else begin
            idx <= idx_p1;
          end
        end
        // Hold the result until the output stage takes it
        S_FIN: begin
          if (res_ready) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

/* design/sorted_priority_queue.sv */
// ----------------------------------------------------------------------------
// sorted_priority_queue
// Priority queue of DEPTH entries kept sorted by signed priority.
//
// Input stream (s_axis): one request per transfer. tuser selects insert or
// remove; tdata carries the data word and priority for an insert.
// Output stream (m_axis): exactly one result per request. tuser carries the
// status (ok, full, empty); tdata carries the removed entry, zero otherwise.
// Entries of equal priority leave in arrival order.
//
// Timing: the block takes one request at a time. An insert walks from the
// rear past each stored entry of lower priority; a remove shifts every
// entry behind the head forward. Refused requests and inserts into an
// empty queue need no walk. The walk runs through the one memory read
// port, the one write port and, on insert, the single comparator. The
// block is ready again in the cycle after the result leaves the core.
// The result sits in an output register: a stalled receiver holds it there
// and the block stops taking requests only once a second result is ready.
// Reset empties the queue; the entry memory needs no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_priority_queue import spq_pkg::*; (
  input  wire logic         clk,
  input  wire logic         rst,
  // request stream
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  input  wire logic [63:0]  s_axis_tdata,   // item_value[31:0], item_priority[63:32]
  input  wire logic [0:0]   s_axis_tuser,   // req_type[0]
  // result stream
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  output logic [63:0]       m_axis_tdata,   // head_value[31:0], head_priority[63:32]
  output logic [1:0]        m_axis_tuser    // status[1:0]
);

  entry_t  req_entry;
  logic    res_valid;
  logic    res_ready;
  result_t res;
  result_t out_res;

  assign req_entry.value = s_axis_tdata[31:0];
  assign req_entry.prio  = s_axis_tdata[63:32];

  spq_core u_core (
    .clk       (clk),
    .rst       (rst),
    .req_valid (s_axis_tvalid),
    .req_ready (s_axis_tready),
    .req_type  (s_axis_tuser[0]),
    .req_entry (req_entry),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  // Output register: load when empty or being drained
  assign res_ready = !m_axis_tvalid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (res_ready) begin
      m_axis_tvalid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_res <= res;
    end
  end

  assign m_axis_tdata = {out_res.prio, out_res.value};
  assign m_axis_tuser = out_res.status;

endmodule

`default_nettype wire

/* bench/sorted_priority_queue_tb.sv */
// ----------------------------------------------------------------------------
// sorted_priority_queue_tb
// Self-checking bench for the sorted priority queue.
//
// Requests go in on the s_axis stream and results come back on m_axis.
// A tracker object keeps its own sorted copy of the queue and computes the
// expected result of every accepted request. Each returned result is
// compared field by field with the oldest outstanding expectation. The
// directed part covers the empty and full cases, priority extremes and
// ties. The random part runs in phases that lean toward insert or remove,
// with wide or narrow priorities. Both sides idle randomly but in quiet phases.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_priority_queue_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import spq_pkg::*;

  localparam int STALL_LIMIT = 2000;
  localparam int PHASES      = 30;
  localparam int PHASE_ITEMS = 61;

  // One expected or observed result
  typedef struct packed {
    status_t             status;
    logic [WORD_W-1:0]   head_val;
    logic [WORD_W-1:0]   head_pri;
  } outcome_t;

  // Tracks queue contents and holds the results still owed by the block
  class pq_tracker;
    logic signed [WORD_W-1:0] vals [DEPTH];
    logic signed [WORD_W-1:0] pris [DEPTH];
    int       fill;
    outcome_t due_outcomes [$];
    int       faults;

    function new();
      fill   = 0;
      faults = 0;
    endfunction

    // Apply one accepted request and queue up its expected result
    function void log_request(logic req, logic [WORD_W-1:0] val,
                              logic [WORD_W-1:0] pri);
      outcome_t o;
      int       k;
      o.status   = ST_OK;
      o.head_val = '0;
      o.head_pri = '0;
      if (req == REQ_INSERT) begin
        if (fill >= DEPTH) begin
          o.status = ST_FULL;
        end else begin
          // Walk from the rear past every entry of lower priority
          k = fill;
          while (k > 0 && $signed(pri) > pris[k-1]) begin
            vals[k] = vals[k-1];
            pris[k] = pris[k-1];
            k--;
          end
          vals[k] = val;
          pris[k] = pri;
          fill++;
        end
      end else begin
        if (fill == 0) begin
          o.status = ST_EMPTY;
        end else begin
          o.head_val = vals[0];
          o.head_pri = pris[0];
          for (k = 1; k < fill; k++) begin
            vals[k-1] = vals[k];
            pris[k-1] = pris[k];
          end
          fill--;
        end
      end
      due_outcomes.push_back(o);
    endfunction

    // Compare one returned result with the oldest expectation
    function void match_result(logic [1:0] st, logic [WORD_W-1:0] hv,
                               logic [WORD_W-1:0] hp);
      outcome_t o;
      if (due_outcomes.size() == 0) begin
        $error("result transfer with no request outstanding: status %0d", st);
        faults++;
        return;
      end
      o = due_outcomes.pop_front();
      if (st !== o.status) begin
        $error("status: expected %0d, got %0d", o.status, st);
        faults++;
      end
      if (hv !== o.head_val) begin
        $error("head_value: expected %h, got %h", o.head_val, hv);
        faults++;
      end
      if (hp !== o.head_pri) begin
        $error("head_priority: expected %h, got %h", o.head_pri, hp);
        faults++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst           = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata  = '0;   // item_value[31:0], item_priority[63:32]
  logic [0:0]  s_axis_tuser  = '0;   // req_type[0]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [63:0] m_axis_tdata;         // head_value[31:0], head_priority[63:32]
  logic [1:0]  m_axis_tuser;         // status[1:0]

  // Set during phases that run both sides without idle cycles
  bit quiet = 1'b0;

  pq_tracker tracker = new();

  sorted_priority_queue u_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  // 10 ns clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Present one request after a random gap and hold it until the transfer
  task automatic send_request(input logic req, input logic [WORD_W-1:0] val,
                              input logic [WORD_W-1:0] pri);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {pri, val};
    s_axis_tuser  <= req;
    do @(posedge clk); while (!s_axis_tready);
    tracker.log_request(req, val, pri);
    @(negedge clk);
  endtask

  // Hold off requests until every outstanding result has come back
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    do @(negedge clk); while (tracker.due_outcomes.size() != 0);
  endtask

  // Result side: random backpressure, check every transfer
  initial begin
    int gap;
    wait (!rst);
    @(negedge clk);
    forever begin
      gap = quiet ? 0 : $urandom_range(0, 11);
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk); while (!m_axis_tvalid);
      tracker.match_result(m_axis_tuser, m_axis_tdata[31:0], m_axis_tdata[63:32]);
      @(negedge clk);
    end
  end

  // Abort when neither stream moves for too long
  initial begin
    int idle;
    idle = 0;
    forever begin
      @(posedge clk);
      if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        idle = 0;
      else
        idle++;
      if (idle >= STALL_LIMIT) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  // Stimulus
  initial begin
    int          pct_table [6];
    int          ins_pct;
    bit          narrow;
    logic        req;
    logic [31:0] pri;

    pct_table = '{85, 15, 50, 60, 97, 3};
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Remove from an empty queue
    send_request(REQ_REMOVE, 32'hDEAD_BEEF, 32'h1234_5678);
    // Fill with extreme priorities and ties
    send_request(REQ_INSERT, 32'h0000_0000, 32'h7FFF_FFFF);
    send_request(REQ_INSERT, 32'hFFFF_FFFF, 32'h8000_0000);
    send_request(REQ_INSERT, 32'h8000_0000, 32'h0000_0000);
    send_request(REQ_INSERT, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
    send_request(REQ_INSERT, 32'h0000_0001, 32'h0000_0005);
    send_request(REQ_INSERT, 32'h0000_0002, 32'h0000_0005);
    send_request(REQ_INSERT, 32'h0000_0003, 32'h0000_0005);
    send_request(REQ_INSERT, 32'hA5A5_5A5A, 32'h8000_0000);
    // Insert into a full queue
    send_request(REQ_INSERT, 32'h5A5A_A5A5, 32'h7FFF_FFFF);
    // Empty it again, then one remove too many
    repeat (DEPTH + 1) send_request(REQ_REMOVE, $urandom, $urandom);
    // Tie at the top priority, served in arrival order
    send_request(REQ_INSERT, 32'h1111_1111, 32'h7FFF_FFFF);
    send_request(REQ_INSERT, 32'h2222_2222, 32'h7FFF_FFFF);
    send_request(REQ_REMOVE, 32'h0, 32'h0);
    send_request(REQ_REMOVE, 32'h0, 32'h0);
    drain_results();

    // Random phases with varying insert share and priority spread
    for (int ph = 0; ph < PHASES; ph++) begin
      ins_pct = pct_table[ph % 6];
      narrow  = ($urandom_range(0, 2) == 0);
      quiet   = (ph % 6 == 3);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        req = ($urandom_range(0, 99) < ins_pct) ? REQ_INSERT : REQ_REMOVE;
        pri = narrow ? 32'($urandom_range(0, 6)) - 32'd3 : $urandom;
        send_request(req, $urandom, pri);
      end
      if (ph % 5 == 4) drain_results();
    end
    quiet = 1'b0;

    drain_results();
    repeat (DEPTH + 8) @(posedge clk);
    if (tracker.faults == 0 && tracker.due_outcomes.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire
